FILE: rtl/aivdm_pkg.sv
// ----------------------------------------------------------------------------
// aivdm_pkg
// Shared types, constants and helpers of the AIVDM sentence framer.
// ----------------------------------------------------------------------------
package aivdm_pkg;

  localparam int FragmentChars = 56;
  localparam int MaxFragments  = 9;
  localparam int QueueDepth    = 2;

  localparam int CharW  = 8;
  localparam int LenW   = 9;
  localparam int FillW  = 3;
  localparam int FragW  = 4;
  localparam int InTdataW = 24;

  localparam logic [CharW-1:0] ChannelReset = 8'h41;  // 'A'

  localparam logic [7:0] ChBang  = 8'h21;  // '!'
  localparam logic [7:0] ChComma = 8'h2C;  // ','
  localparam logic [7:0] ChStar  = 8'h2A;  // '*'
  localparam logic [7:0] ChZero  = 8'h30;  // '0'
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChA     = 8'h41;
  localparam logic [7:0] ChI     = 8'h49;
  localparam logic [7:0] ChV     = 8'h56;
  localparam logic [7:0] ChD     = 8'h44;
  localparam logic [7:0] ChM     = 8'h4D;

  // Classified item handed from the front to the back.
  typedef struct packed {
    logic [CharW-1:0] payload;
    logic [FragW-1:0] count;
    logic [FragW-1:0] frag;
    logic [FillW-1:0] fill;
    logic             header;
    logic             seq;
    logic             trailer;
    logic             last;
  } desc_t;

  // One code per byte slot of a sentence.
  typedef enum logic [4:0] {
    StBang, StTagA, StTagI, StTagV, StTagD, StTagM, StComma1,
    StCount, StComma2, StFrag, StComma3, StSeq, StComma4,
    StChan, StComma5, StData, StTComma, StFill, StStar,
    StHexHi, StHexLo, StCr, StLf
  } step_e;

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    hex_char = (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h37 + {4'h0, v});
  endfunction

endpackage

FILE: rtl/aivdm_front.sv
// ----------------------------------------------------------------------------
// aivdm_front
// Tracks the position in the message and classifies each accepted item.
// ----------------------------------------------------------------------------
module aivdm_front #(
  parameter int FRAGMENT_CHARS = aivdm_pkg::FragmentChars,
  parameter int MAX_FRAGMENTS  = aivdm_pkg::MaxFragments
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [aivdm_pkg::CharW-1:0]   payload_char_i,
  input  logic [aivdm_pkg::LenW-1:0]    message_length_i,
  input  logic [aivdm_pkg::FillW-1:0]   fill_bits_i,
  output logic                          push_valid_o,
  input  logic                          push_ready_i,
  output aivdm_pkg::desc_t              push_desc_o
);

  localparam int IdxW = (FRAGMENT_CHARS > 1) ? $clog2(FRAGMENT_CHARS) : 1;
  localparam int EffW = aivdm_pkg::LenW + 1;
  localparam int Cap  = FRAGMENT_CHARS * MAX_FRAGMENTS;
  localparam logic [EffW-1:0] CapV = EffW'(Cap);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(FRAGMENT_CHARS - 1);

  logic [aivdm_pkg::LenW-1:0]  pos_q, pos_d;
  logic [IdxW-1:0]             idx_q, idx_d;
  logic [aivdm_pkg::FragW-1:0] frag_q, frag_d;

  logic [aivdm_pkg::LenW-1:0]  len;
  logic [EffW-1:0]             eff_cap, eff, pos_inc;
  logic [aivdm_pkg::FragW-1:0] count;
  logic                        last, frag_end, accept;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign accept       = in_valid_i && push_ready_i;

  always_comb begin
    len     = (message_length_i == '0) ? aivdm_pkg::LenW'(1) : message_length_i;
    eff_cap = ({1'b0, len} < CapV) ? {1'b0, len} : CapV;
    pos_inc = {1'b0, pos_q} + EffW'(1);
    eff     = ({1'b0, pos_q} >= eff_cap) ? pos_inc : eff_cap;
    // fragment count: how many fragment starts lie below the length
    count = '0;
    for (int k = 0; k < MAX_FRAGMENTS; k++) begin
      count = count + aivdm_pkg::FragW'(eff > EffW'(k * FRAGMENT_CHARS));
    end
    last     = pos_inc >= eff;
    frag_end = last || (idx_q == LastIdx);
  end

  always_comb begin
    push_desc_o.payload = payload_char_i;
    push_desc_o.count   = count;
    push_desc_o.frag    = frag_q;
    push_desc_o.fill    = fill_bits_i;
    push_desc_o.header  = (idx_q == '0);
    push_desc_o.seq     = (count > aivdm_pkg::FragW'(1));
    push_desc_o.trailer = frag_end;
    push_desc_o.last    = last;
  end

  always_comb begin
    pos_d  = pos_q;
    idx_d  = idx_q;
    frag_d = frag_q;
    if (accept) begin
      if (last) begin
        pos_d  = '0;
        idx_d  = '0;
        frag_d = '0;
      end else begin
        pos_d = pos_inc[aivdm_pkg::LenW-1:0];
        if (idx_q == LastIdx) begin
          idx_d  = '0;
          frag_d = frag_q + aivdm_pkg::FragW'(1);
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      idx_q  <= '0;
      frag_q <= '0;
    end else begin
      pos_q  <= pos_d;
      idx_q  <= idx_d;
      frag_q <= frag_d;
    end
  end

endmodule

FILE: rtl/aivdm_queue.sv
// ----------------------------------------------------------------------------
// aivdm_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
module aivdm_queue #(
  parameter int DEPTH = aivdm_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  aivdm_pkg::desc_t push_desc_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output aivdm_pkg::desc_t pop_desc_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  aivdm_pkg::desc_t mem_q [DEPTH];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CntW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_desc_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: rtl/aivdm_back.sv
// ----------------------------------------------------------------------------
// aivdm_back
// Byte sequencer: walks the sentence slots of one item, keeps the checksum
// and drives the registered output stream.
// ----------------------------------------------------------------------------
module aivdm_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [aivdm_pkg::CharW-1:0] channel_i,
  input  logic                        pop_valid_i,
  output logic                        pop_ready_o,
  input  aivdm_pkg::desc_t            pop_desc_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [7:0]                  out_byte_o,
  output logic                        out_last_o,
  output logic [1:0]                  out_user_o
);

  aivdm_pkg::step_e step_q, step_d, cur;
  logic [7:0] csum_q, csum_d;
  logic [7:0] byte_v;
  logic       summed, done, emit, can_load;
  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       last_q, sent_q, msg_q;

  assign can_load    = !valid_q || out_ready_i;
  assign emit        = pop_valid_i && can_load;
  assign pop_ready_o = emit && done;

  always_comb begin
    // skip the header when the item continues a fragment
    cur = (step_q == aivdm_pkg::StBang && !pop_desc_i.header) ?
          aivdm_pkg::StData : step_q;
    byte_v = aivdm_pkg::ChComma;
    summed = 1'b1;
    done   = 1'b0;
    step_d = step_q;
    case (cur)
      aivdm_pkg::StBang: begin
        byte_v = aivdm_pkg::ChBang;
        summed = 1'b0;
        step_d = aivdm_pkg::StTagA;
      end
      aivdm_pkg::StTagA: begin byte_v = aivdm_pkg::ChA; step_d = aivdm_pkg::StTagI; end
      aivdm_pkg::StTagI: begin byte_v = aivdm_pkg::ChI; step_d = aivdm_pkg::StTagV; end
      aivdm_pkg::StTagV: begin byte_v = aivdm_pkg::ChV; step_d = aivdm_pkg::StTagD; end
      aivdm_pkg::StTagD: begin byte_v = aivdm_pkg::ChD; step_d = aivdm_pkg::StTagM; end
      aivdm_pkg::StTagM: begin byte_v = aivdm_pkg::ChM; step_d = aivdm_pkg::StComma1; end
      aivdm_pkg::StComma1: step_d = aivdm_pkg::StCount;
      aivdm_pkg::StCount: begin
        byte_v = aivdm_pkg::ChZero + {4'h0, pop_desc_i.count};
        step_d = aivdm_pkg::StComma2;
      end
      aivdm_pkg::StComma2: step_d = aivdm_pkg::StFrag;
      aivdm_pkg::StFrag: begin
        byte_v = aivdm_pkg::ChZero + {4'h0, pop_desc_i.frag} + 8'd1;
        step_d = aivdm_pkg::StComma3;
      end
      aivdm_pkg::StComma3: step_d = pop_desc_i.seq ? aivdm_pkg::StSeq : aivdm_pkg::StComma4;
      aivdm_pkg::StSeq: begin
        byte_v = aivdm_pkg::ChZero;
        step_d = aivdm_pkg::StComma4;
      end
      aivdm_pkg::StComma4: step_d = aivdm_pkg::StChan;
      aivdm_pkg::StChan: begin
        byte_v = channel_i;
        step_d = aivdm_pkg::StComma5;
      end
      aivdm_pkg::StComma5: step_d = aivdm_pkg::StData;
      aivdm_pkg::StData: begin
        byte_v = pop_desc_i.payload;
        if (pop_desc_i.trailer) begin
          step_d = aivdm_pkg::StTComma;
        end else begin
          step_d = aivdm_pkg::StBang;
          done   = 1'b1;
        end
      end
      aivdm_pkg::StTComma: step_d = aivdm_pkg::StFill;
      aivdm_pkg::StFill: begin
        byte_v = pop_desc_i.last ? (aivdm_pkg::ChZero + {5'h0, pop_desc_i.fill}) :
                 aivdm_pkg::ChZero;
        step_d = aivdm_pkg::StStar;
      end
      aivdm_pkg::StStar: begin
        byte_v = aivdm_pkg::ChStar;
        summed = 1'b0;
        step_d = aivdm_pkg::StHexHi;
      end
      aivdm_pkg::StHexHi: begin
        byte_v = aivdm_pkg::hex_char(csum_q[7:4]);
        summed = 1'b0;
        step_d = aivdm_pkg::StHexLo;
      end
      aivdm_pkg::StHexLo: begin
        byte_v = aivdm_pkg::hex_char(csum_q[3:0]);
        summed = 1'b0;
        step_d = aivdm_pkg::StCr;
      end
      aivdm_pkg::StCr: begin
        byte_v = aivdm_pkg::ChCr;
        summed = 1'b0;
        step_d = aivdm_pkg::StLf;
      end
      aivdm_pkg::StLf: begin
        byte_v = aivdm_pkg::ChLf;
        summed = 1'b0;
        step_d = aivdm_pkg::StBang;
        done   = 1'b1;
      end
      default: begin
        summed = 1'b0;
        step_d = aivdm_pkg::StBang;
      end
    endcase
    if (!emit) begin
      step_d = step_q;
    end
  end

  always_comb begin
    csum_d = csum_q;
    if (emit) begin
      if (cur == aivdm_pkg::StBang) begin
        csum_d = '0;  // new sentence
      end else if (summed) begin
        csum_d = csum_q ^ byte_v;
      end
    end
    valid_d = valid_q;
    if (emit) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= aivdm_pkg::StBang;
      csum_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      step_q  <= step_d;
      csum_q  <= csum_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q <= byte_v;
      last_q <= done;
      sent_q <= (cur == aivdm_pkg::StLf);
      msg_q  <= (cur == aivdm_pkg::StLf) && pop_desc_i.last;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;
  assign out_user_o  = {msg_q, sent_q};

endmodule

FILE: rtl/nmea_aivdm_sentence_framer_core.sv
// ----------------------------------------------------------------------------
// nmea_aivdm_sentence_framer_core
// Frames armored payload characters into AIVDM sentences, one byte a cycle while not stalled.
// ----------------------------------------------------------------------------
// Path: an accepted item is written into the queue, then the back part registers its first byte
//   onto the output. Throughput: one output byte per cycle while m_axis_tready is high; a
//   mid-fragment item gives its payload byte only, a fragment start adds the header and a
//   fragment end the trailer, set by the byte sequencer in the back part. A 2-entry queue lets the input run ahead.
// Reset: clears position, checksum, queue and output; channel returns to 'A'.
module nmea_aivdm_sentence_framer_core #(
  parameter int FRAGMENT_CHARS = aivdm_pkg::FragmentChars,
  parameter int MAX_FRAGMENTS  = aivdm_pkg::MaxFragments
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [aivdm_pkg::CharW-1:0]    cfg_wdata_i,      // channel_code
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [7:0] payload_char, [16:8] message_length, [19:17] fill_bits, [23:20] zero
  input  logic [aivdm_pkg::InTdataW-1:0] s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,     // [7:0] out_byte
  output logic                           m_axis_tlast,     // last_of_run
  output logic [1:0]                     m_axis_tuser      // [0] sentence_end, [1] message_end
);

  logic [aivdm_pkg::CharW-1:0] channel_q;
  logic             push_valid, push_ready, pop_valid, pop_ready;
  aivdm_pkg::desc_t push_desc, pop_desc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_q <= aivdm_pkg::ChannelReset;
    end else if (cfg_we_i) begin
      channel_q <= cfg_wdata_i;
    end
  end

  aivdm_front #(
    .FRAGMENT_CHARS(FRAGMENT_CHARS),
    .MAX_FRAGMENTS (MAX_FRAGMENTS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .payload_char_i  (s_axis_tdata[7:0]),
    .message_length_i(s_axis_tdata[16:8]),
    .fill_bits_i     (s_axis_tdata[19:17]),
    .push_valid_o    (push_valid),
    .push_ready_i    (push_ready),
    .push_desc_o     (push_desc)
  );

  aivdm_queue #(
    .DEPTH(aivdm_pkg::QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_desc_i (push_desc),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_desc_o  (pop_desc)
  );

  aivdm_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .channel_i  (channel_q),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_desc_i (pop_desc),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_byte_o (m_axis_tdata),
    .out_last_o (m_axis_tlast),
    .out_user_o (m_axis_tuser)
  );

endmodule
